// ----- hdl/kfa_pkg.sv -----
// Package for the constant-acceleration Kalman filter core.
// Holds the microcode ROM, register-file map, opcodes and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package kfa_pkg;

  localparam int DATA_W = 64;
  localparam int RF_AW  = 6;
  localparam int RF_DEPTH = 64;
  localparam int PC_W   = 7;

  // Micro-operations.
  localparam logic [2:0] OP_END  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_DIVK = 3'd5;
  localparam logic [2:0] OP_LDI  = 3'd6;
  localparam logic [2:0] OP_OUT  = 3'd7;

  // Load sources for OP_LDI, carried in the b field.
  localparam logic [RF_AW-1:0] SRC_ZERO = 6'd0;
  localparam logic [RF_AW-1:0] SRC_DT   = 6'd1;
  localparam logic [RF_AW-1:0] SRC_SIG  = 6'd2;
  localparam logic [RF_AW-1:0] SRC_R    = 6'd3;
  localparam logic [RF_AW-1:0] SRC_P    = 6'd4;
  localparam logic [RF_AW-1:0] SRC_Z    = 6'd5;

  // Constant divisors for OP_DIVK, carried in the b field.
  localparam logic [RF_AW-1:0] K_2  = 6'd0;
  localparam logic [RF_AW-1:0] K_6  = 6'd1;
  localparam logic [RF_AW-1:0] K_12 = 6'd2;

  // Register-file map.
  localparam logic [RF_AW-1:0] X0 = 6'd0, X1 = 6'd1, X2 = 6'd2;
  localparam logic [RF_AW-1:0] P0 = 6'd3, P1 = 6'd4, P2 = 6'd5, P3 = 6'd6, P4 = 6'd7;
  localparam logic [RF_AW-1:0] P5 = 6'd8, P6 = 6'd9, P7 = 6'd10, P8 = 6'd11;
  localparam logic [RF_AW-1:0] T0 = 6'd12, T1 = 6'd13;
  localparam logic [RF_AW-1:0] Q00 = 6'd14, Q01 = 6'd15, Q02 = 6'd16, Q12 = 6'd17;
  localparam logic [RF_AW-1:0] Q22 = 6'd18;
  localparam logic [RF_AW-1:0] ZV = 6'd19, RR = 6'd20, SIG = 6'd21;
  localparam logic [RF_AW-1:0] D2 = 6'd22, D3 = 6'd23, D4 = 6'd24, D5 = 6'd25, D6 = 6'd26;
  localparam logic [RF_AW-1:0] M0 = 6'd27, M1 = 6'd28, M2 = 6'd29, M3 = 6'd30;
  localparam logic [RF_AW-1:0] M4 = 6'd31, M5 = 6'd32;
  localparam logic [RF_AW-1:0] K0 = 6'd33, K1 = 6'd34, K2 = 6'd35;
  localparam logic [RF_AW-1:0] SV = 6'd36, YV = 6'd37, TMP = 6'd38, TMP2 = 6'd39;
  localparam logic [RF_AW-1:0] NA = 6'd0;

  // Program entry points.
  localparam logic [PC_W-1:0] PC_REBUILD = 7'd0;
  localparam logic [PC_W-1:0] PC_REINIT  = 7'd18;
  localparam logic [PC_W-1:0] PC_FIRST   = 7'd31;
  localparam logic [PC_W-1:0] PC_STEP    = 7'd36;

  typedef struct packed {
    logic [2:0]       op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
  } uinstr_t;

  typedef struct packed {
    logic             go;
    logic [2:0]       op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
  } kfa_cmd_t;

  typedef struct packed {
    logic done;
  } kfa_stat_t;

  function automatic uinstr_t mk(logic [2:0] op, logic [RF_AW-1:0] dst,
                                 logic [RF_AW-1:0] a, logic [RF_AW-1:0] b);
    uinstr_t u;
    u.op = op;
    u.dst = dst;
    u.a = a;
    u.b = b;
    return u;
  endfunction

  function automatic uinstr_t ucode(logic [PC_W-1:0] pc);
    uinstr_t u;
    unique case (pc)
      // Rebuild of A and Q from dt and sigma.
      7'd0:   u = mk(OP_LDI, T0, NA, SRC_DT);
      7'd1:   u = mk(OP_MUL, D2, T0, T0);
      7'd2:   u = mk(OP_MUL, D3, D2, T0);
      7'd3:   u = mk(OP_MUL, D4, D3, T0);
      7'd4:   u = mk(OP_MUL, D5, D4, T0);
      7'd5:   u = mk(OP_MUL, D6, D5, T0);
      7'd6:   u = mk(OP_LDI, SIG, NA, SRC_SIG);
      7'd7:   u = mk(OP_DIVK, TMP, D6, K_6);
      7'd8:   u = mk(OP_MUL, Q00, TMP, SIG);
      7'd9:   u = mk(OP_DIVK, TMP, D5, K_12);
      7'd10:  u = mk(OP_MUL, Q01, TMP, SIG);
      7'd11:  u = mk(OP_DIVK, TMP, D4, K_6);
      7'd12:  u = mk(OP_MUL, Q02, TMP, SIG);
      7'd13:  u = mk(OP_DIVK, TMP, D3, K_2);
      7'd14:  u = mk(OP_MUL, Q12, TMP, SIG);
      7'd15:  u = mk(OP_MUL, Q22, D2, SIG);
      7'd16:  u = mk(OP_DIVK, T1, D2, K_2);
      7'd17:  u = mk(OP_END, NA, NA, NA);
      // Re-initialization.
      7'd18:  u = mk(OP_LDI, X0, NA, SRC_ZERO);
      7'd19:  u = mk(OP_LDI, X1, NA, SRC_ZERO);
      7'd20:  u = mk(OP_LDI, X2, NA, SRC_ZERO);
      7'd21:  u = mk(OP_LDI, P0, NA, SRC_P);
      7'd22:  u = mk(OP_LDI, P1, NA, SRC_ZERO);
      7'd23:  u = mk(OP_LDI, P2, NA, SRC_ZERO);
      7'd24:  u = mk(OP_LDI, P3, NA, SRC_ZERO);
      7'd25:  u = mk(OP_LDI, P4, NA, SRC_P);
      7'd26:  u = mk(OP_LDI, P5, NA, SRC_ZERO);
      7'd27:  u = mk(OP_LDI, P6, NA, SRC_ZERO);
      7'd28:  u = mk(OP_LDI, P7, NA, SRC_ZERO);
      7'd29:  u = mk(OP_LDI, P8, NA, SRC_P);
      7'd30:  u = mk(OP_END, NA, NA, NA);
      // First sample: load the position only.
      7'd31:  u = mk(OP_LDI, X0, NA, SRC_Z);
      7'd32:  u = mk(OP_OUT, NA, X0, 6'd0);
      7'd33:  u = mk(OP_OUT, NA, X1, 6'd1);
      7'd34:  u = mk(OP_OUT, NA, X2, 6'd2);
      7'd35:  u = mk(OP_END, NA, NA, NA);
      // Full filter step: state prediction.
      7'd36:  u = mk(OP_LDI, ZV, NA, SRC_Z);
      7'd37:  u = mk(OP_MUL, TMP, T0, X1);
      7'd38:  u = mk(OP_ADD, X0, X0, TMP);
      7'd39:  u = mk(OP_MUL, TMP, T1, X2);
      7'd40:  u = mk(OP_ADD, X0, X0, TMP);
      7'd41:  u = mk(OP_MUL, TMP, T0, X2);
      7'd42:  u = mk(OP_ADD, X1, X1, TMP);
      // M = A P, one column at a time.
      7'd43:  u = mk(OP_MUL, TMP, T0, P3);
      7'd44:  u = mk(OP_ADD, M0, P0, TMP);
      7'd45:  u = mk(OP_MUL, TMP, T1, P6);
      7'd46:  u = mk(OP_ADD, M0, M0, TMP);
      7'd47:  u = mk(OP_MUL, TMP, T0, P6);
      7'd48:  u = mk(OP_ADD, M3, P3, TMP);
      7'd49:  u = mk(OP_MUL, TMP, T0, P4);
      7'd50:  u = mk(OP_ADD, M1, P1, TMP);
      7'd51:  u = mk(OP_MUL, TMP, T1, P7);
      7'd52:  u = mk(OP_ADD, M1, M1, TMP);
      7'd53:  u = mk(OP_MUL, TMP, T0, P7);
      7'd54:  u = mk(OP_ADD, M4, P4, TMP);
      7'd55:  u = mk(OP_MUL, TMP, T0, P5);
      7'd56:  u = mk(OP_ADD, M2, P2, TMP);
      7'd57:  u = mk(OP_MUL, TMP, T1, P8);
      7'd58:  u = mk(OP_ADD, M2, M2, TMP);
      7'd59:  u = mk(OP_MUL, TMP, T0, P8);
      7'd60:  u = mk(OP_ADD, M5, P5, TMP);
      // P = M A^T + Q, one row at a time. The last row of M is the last row of P.
      7'd61:  u = mk(OP_MUL, TMP, T0, M1);
      7'd62:  u = mk(OP_ADD, TMP2, M0, TMP);
      7'd63:  u = mk(OP_MUL, TMP, T1, M2);
      7'd64:  u = mk(OP_ADD, TMP2, TMP2, TMP);
      7'd65:  u = mk(OP_ADD, P0, TMP2, Q00);
      7'd66:  u = mk(OP_MUL, TMP, T0, M2);
      7'd67:  u = mk(OP_ADD, TMP2, M1, TMP);
      7'd68:  u = mk(OP_ADD, P1, TMP2, Q01);
      7'd69:  u = mk(OP_ADD, P2, M2, Q02);
      7'd70:  u = mk(OP_MUL, TMP, T0, M4);
      7'd71:  u = mk(OP_ADD, TMP2, M3, TMP);
      7'd72:  u = mk(OP_MUL, TMP, T1, M5);
      7'd73:  u = mk(OP_ADD, TMP2, TMP2, TMP);
      7'd74:  u = mk(OP_ADD, P3, TMP2, Q01);
      7'd75:  u = mk(OP_MUL, TMP, T0, M5);
      7'd76:  u = mk(OP_ADD, TMP2, M4, TMP);
      7'd77:  u = mk(OP_ADD, P4, TMP2, Q02);
      7'd78:  u = mk(OP_ADD, P5, M5, Q12);
      7'd79:  u = mk(OP_MUL, TMP, T0, P7);
      7'd80:  u = mk(OP_ADD, TMP2, P6, TMP);
      7'd81:  u = mk(OP_MUL, TMP, T1, P8);
      7'd82:  u = mk(OP_ADD, TMP2, TMP2, TMP);
      7'd83:  u = mk(OP_ADD, P6, TMP2, Q02);
      7'd84:  u = mk(OP_MUL, TMP, T0, P8);
      7'd85:  u = mk(OP_ADD, TMP2, P7, TMP);
      7'd86:  u = mk(OP_ADD, P7, TMP2, Q12);
      7'd87:  u = mk(OP_ADD, P8, P8, Q22);
      // Gain.
      7'd88:  u = mk(OP_LDI, RR, NA, SRC_R);
      7'd89:  u = mk(OP_ADD, SV, P0, RR);
      7'd90:  u = mk(OP_DIV, K0, P0, SV);
      7'd91:  u = mk(OP_DIV, K1, P3, SV);
      7'd92:  u = mk(OP_DIV, K2, P6, SV);
      // Correction.
      7'd93:  u = mk(OP_SUB, YV, ZV, X0);
      7'd94:  u = mk(OP_MUL, TMP, K0, YV);
      7'd95:  u = mk(OP_ADD, X0, X0, TMP);
      7'd96:  u = mk(OP_MUL, TMP, K1, YV);
      7'd97:  u = mk(OP_ADD, X1, X1, TMP);
      7'd98:  u = mk(OP_MUL, TMP, K2, YV);
      7'd99:  u = mk(OP_ADD, X2, X2, TMP);
      // Covariance update. Rows 1 and 2 go first since they read the old row 0.
      7'd100: u = mk(OP_MUL, TMP, K1, P0);
      7'd101: u = mk(OP_SUB, P3, P3, TMP);
      7'd102: u = mk(OP_MUL, TMP, K1, P1);
      7'd103: u = mk(OP_SUB, P4, P4, TMP);
      7'd104: u = mk(OP_MUL, TMP, K1, P2);
      7'd105: u = mk(OP_SUB, P5, P5, TMP);
      7'd106: u = mk(OP_MUL, TMP, K2, P0);
      7'd107: u = mk(OP_SUB, P6, P6, TMP);
      7'd108: u = mk(OP_MUL, TMP, K2, P1);
      7'd109: u = mk(OP_SUB, P7, P7, TMP);
      7'd110: u = mk(OP_MUL, TMP, K2, P2);
      7'd111: u = mk(OP_SUB, P8, P8, TMP);
      7'd112: u = mk(OP_MUL, TMP, K0, P0);
      7'd113: u = mk(OP_SUB, P0, P0, TMP);
      7'd114: u = mk(OP_MUL, TMP, K0, P1);
      7'd115: u = mk(OP_SUB, P1, P1, TMP);
      7'd116: u = mk(OP_MUL, TMP, K0, P2);
      7'd117: u = mk(OP_SUB, P2, P2, TMP);
      7'd118: u = mk(OP_OUT, NA, X0, 6'd0);
      7'd119: u = mk(OP_OUT, NA, X1, 6'd1);
      7'd120: u = mk(OP_OUT, NA, X2, 6'd2);
      default: u = mk(OP_END, NA, NA, NA);
    endcase
    return u;
  endfunction

endpackage

// ----- hdl/kfa_if.sv -----
// Valid/ready channel interfaces for the Kalman filter core.
// Depends on nothing.
`timescale 1ns / 1ps

interface kfa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface kfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] acceleration;
  modport source (output valid, output position, output velocity, output acceleration,
                  input ready);
  modport sink (input valid, input position, input velocity, input acceleration,
                output ready);
endinterface

// ----- hdl/kfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/kfa_datapath.sv -----
// Datapath: two-read register file, saturating adder, multi-cycle multiplier
// and bit-serial divider. Depends on kfa_pkg and kfa_ram.
`timescale 1ns / 1ps

module kfa_datapath #(
  parameter int STATE_FRAC_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  kfa_pkg::kfa_cmd_t  cmd,
  output kfa_pkg::kfa_stat_t stat,
  input  logic [31:0]        time_step,
  input  logic [30:0]        accel_noise_scale,
  input  logic [30:0]        measurement_noise,
  input  logic [30:0]        initial_covariance,
  input  logic signed [31:0] sample,
  output logic signed [31:0] hold_pos,
  output logic signed [31:0] hold_vel,
  output logic signed [31:0] hold_acc
);
  import kfa_pkg::*;

  localparam int SH = STATE_FRAC_BITS - 16;
  localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SMIN = {1'b1, {63{1'b0}}};
  localparam logic [127:0] RND = 128'd1 << (STATE_FRAC_BITS - 1);
  // ceil(2^65 / 3): the product's bits from 65 up give the quotient by three.
  localparam logic [63:0] RECIP3 = 64'hAAAA_AAAA_AAAA_AAAB;

  function automatic logic [63:0] mag(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] from_mag(logic [63:0] m, logic neg);
    logic [63:0] r;
    if (neg) r = m[63] ? SMIN : (64'd0 - m);
    else r = m[63] ? SMAX : m;
    return r;
  endfunction

  function automatic logic [63:0] sat_sum(logic [64:0] s);
    logic [63:0] r;
    if (s[64] != s[63]) r = s[64] ? SMIN : SMAX;
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic [63:0] to_int(logic [63:0] v);
    logic [63:0] m;
    m = mag(v);
    if ((m >> (63 - SH)) != 64'd0) m = '1;
    else m = m << SH;
    return from_mag(m, v[63]);
  endfunction

  function automatic logic [31:0] to_out(logic [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    logic [31:0] o;
    m = mag(x);
    r = (m >> SH) + ((m >> (SH - 1)) & 64'd1);
    if (x[63]) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      o = 32'd0 - r[31:0];
    end else begin
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      o = r[31:0];
    end
    return o;
  endfunction

  // Register file, duplicated for two read ports.
  logic             we;
  logic [63:0]      ra;
  logic [63:0]      rb;
  logic [63:0]      res;
  logic [RF_AW-1:0] dst_q;
  logic             wr;
  logic             out_done;
  logic             go_wr;

  kfa_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk(clk), .we(we), .waddr(dst_q), .wdata(res), .raddr(cmd.a), .rdata(ra)
  );
  kfa_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk(clk), .we(we), .waddr(dst_q), .wdata(res), .raddr(cmd.b), .rdata(rb)
  );

  assign we = wr;
  assign stat.done = wr | out_done;

  // Operations that write their result in the cycle after the command.
  always_comb begin
    case (cmd.op) inside
      OP_ADD, OP_SUB, OP_LDI: go_wr = 1'b1;
      OP_DIV:  go_wr = (rb == 64'd0);
      OP_DIVK: go_wr = (cmd.b == K_2);
      default: go_wr = 1'b0;
    endcase
  end

  // Multiplier: four 32x32 partial products, then a rounding step.
  logic          mul_busy;
  logic          kdiv;
  logic [2:0]    mstep;
  logic [63:0]   mx;
  logic [63:0]   my;
  logic [127:0]  acc;
  logic          sneg;
  logic [31:0]   pa;
  logic [31:0]   pb;
  logic [63:0]   prod;
  logic [127:0]  prod_sh;
  logic [127:0]  rsum;
  logic [63:0]   mres;

  always_comb begin
    pa = (mstep[1]) ? mx[63:32] : mx[31:0];
    pb = (mstep[0]) ? my[63:32] : my[31:0];
    prod = {32'd0, pa} * {32'd0, pb};
    case (mstep[1:0])
      2'd0:    prod_sh = {64'd0, prod};
      2'd3:    prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
    rsum = acc + RND;
    if ((rsum >> (64 + STATE_FRAC_BITS)) != 128'd0) mres = '1;
    else mres = 64'(rsum >> STATE_FRAC_BITS);
  end

  // Restoring divider, one quotient bit per cycle.
  logic          div_busy;
  logic          div_fin;
  logic [127:0]  dvd;
  logic [63:0]   rem;
  logic [63:0]   quo;
  logic [63:0]   dvs;
  logic [7:0]    cnt;
  logic          ovf;
  logic [64:0]   remsh;
  logic          take;
  logic [7:0]    idx;
  logic [63:0]   qfin;

  always_comb begin
    remsh = {rem, dvd[127]};
    take = remsh >= {1'b0, dvs};
    idx = cnt - 8'd1;
    if (ovf) qfin = '1;
    else if (rem >= (dvs - rem)) qfin = quo + 64'd1;
    else qfin = quo;
  end

  // Division by 2, 6 or 12: the rounded dividend is shifted by the power of two
  // in the divisor, and a remaining factor of three goes through the multiplier.
  logic [63:0] kval;
  logic [63:0] ksum;
  logic [63:0] kpre;

  always_comb begin
    case (cmd.b)
      K_2:     kval = 64'd2;
      K_6:     kval = 64'd6;
      default: kval = 64'd12;
    endcase
    ksum = mag(ra) + (kval >> 1);
    kpre = (cmd.b == K_12) ? (ksum >> 2) : (ksum >> 1);
  end

  logic [63:0] ldv;
  always_comb begin
    case (cmd.b)
      SRC_DT:  ldv = {32'd0, time_step} << (STATE_FRAC_BITS - 32);
      SRC_SIG: ldv = to_int({33'd0, accel_noise_scale});
      SRC_R:   ldv = to_int({33'd0, measurement_noise});
      SRC_P:   ldv = to_int({33'd0, initial_covariance});
      SRC_Z:   ldv = to_int({{32{sample[31]}}, sample});
      default: ldv = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= 1'b0;
      out_done <= 1'b0;
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      div_fin <= 1'b0;
    end else begin
      wr <= (cmd.go && go_wr) || (mul_busy && (mstep == 3'd4)) || div_fin;
      out_done <= cmd.go && (cmd.op == OP_OUT);
      div_fin <= div_busy && (idx == 8'd0);
      if (cmd.go) begin
        dst_q <= cmd.dst;
        case (cmd.op)
          OP_ADD: begin
            res <= sat_sum({ra[63], ra} + {rb[63], rb});
          end
          OP_SUB: begin
            res <= sat_sum({ra[63], ra} - {rb[63], rb});
          end
          OP_LDI: begin
            res <= ldv;
          end
          OP_OUT: begin
            case (cmd.b[1:0])
              2'd0:    hold_pos <= to_out(ra);
              2'd1:    hold_vel <= to_out(ra);
              default: hold_acc <= to_out(ra);
            endcase
          end
          OP_MUL: begin
            mx <= mag(ra);
            my <= mag(rb);
            sneg <= ra[63] ^ rb[63];
            acc <= '0;
            mstep <= 3'd0;
            kdiv <= 1'b0;
            mul_busy <= 1'b1;
          end
          OP_DIV: begin
            if (rb == 64'd0) begin
              // A zero denominator saturates by the numerator's sign; 0/0 gives zero.
              res <= (ra == 64'd0) ? 64'd0 : (ra[63] ? SMIN : SMAX);
            end else begin
              dvd <= {64'd0, mag(ra)} << STATE_FRAC_BITS;
              dvs <= mag(rb);
              sneg <= ra[63] ^ rb[63];
              cnt <= 8'd128;
              rem <= '0;
              quo <= '0;
              ovf <= 1'b0;
              div_busy <= 1'b1;
            end
          end
          OP_DIVK: begin
            if (cmd.b == K_2) begin
              res <= from_mag(kpre, ra[63]);
            end else begin
              mx <= kpre;
              my <= RECIP3;
              sneg <= ra[63];
              acc <= '0;
              mstep <= 3'd0;
              kdiv <= 1'b1;
              mul_busy <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if (mul_busy) begin
        if (mstep == 3'd4) begin
          res <= from_mag(kdiv ? {1'b0, acc[127:65]} : mres, sneg);
          mul_busy <= 1'b0;
        end else begin
          acc <= acc + prod_sh;
          mstep <= mstep + 3'd1;
        end
      end

      if (div_busy) begin
        dvd <= dvd << 1;
        if (take) begin
          rem <= 64'(remsh - {1'b0, dvs});
          if (idx >= 8'd63) ovf <= 1'b1;
        end else begin
          rem <= remsh[63:0];
        end
        quo <= {quo[62:0], take};
        cnt <= idx;
        if (idx == 8'd0) begin
          div_busy <= 1'b0;
        end
      end

      if (div_fin) begin
        res <= from_mag(qfin, sneg);
      end
    end
  end

endmodule

// ----- hdl/kfa_ctrl.sv -----
// Controller: microcode sequencer that runs the rebuild, re-initialization and
// filter-step programs on the datapath. Depends on kfa_pkg.
`timescale 1ns / 1ps

module kfa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               rebuild_req,
  input  logic               reinit_req,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_free,
  output logic               load_out,
  output kfa_pkg::kfa_cmd_t  cmd,
  input  kfa_pkg::kfa_stat_t stat
);
  import kfa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]      state;
  logic [PC_W-1:0] pc;
  logic            rebuild_pend;
  logic            reinit_pend;
  logic            take_rebuild;
  logic            take_reinit;
  logic            first;
  logic            item_run;
  uinstr_t         ins;

  assign ins = ucode(pc);
  assign in_ready = (state == S_IDLE) && !rebuild_pend && !reinit_pend;
  assign load_out = (state == S_OUT) && out_free;
  assign take_rebuild = (state == S_IDLE) && rebuild_pend;
  assign take_reinit = (state == S_IDLE) && !rebuild_pend && reinit_pend;

  always_comb begin
    cmd.go = (state == S_EXEC) && (ins.op != OP_END);
    cmd.op = ins.op;
    cmd.dst = ins.dst;
    cmd.a = ins.a;
    cmd.b = ins.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= PC_REBUILD;
      rebuild_pend <= 1'b1;
      reinit_pend <= 1'b1;
      first <= 1'b1;
      item_run <= 1'b0;
    end else begin
      rebuild_pend <= rebuild_req || (rebuild_pend && !take_rebuild);
      reinit_pend <= reinit_req || (reinit_pend && !take_reinit);
      unique case (state)
        S_IDLE: begin
          if (rebuild_pend) begin
            pc <= PC_REBUILD;
            item_run <= 1'b0;
            state <= S_FETCH;
          end else if (reinit_pend) begin
            first <= 1'b1;
            pc <= PC_REINIT;
            item_run <= 1'b0;
            state <= S_FETCH;
          end else if (in_valid) begin
            pc <= first ? PC_FIRST : PC_STEP;
            first <= 1'b0;
            item_run <= 1'b1;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          if (ins.op == OP_END) state <= item_run ? S_OUT : S_IDLE;
          else state <= S_WAIT;
        end
        S_WAIT: begin
          if (stat.done) begin
            pc <= pc + 1'b1;
            state <= S_FETCH;
          end
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/kalman_filter_pos_vel_acc_core.sv -----
// Constant-acceleration Kalman filter core (position, velocity, acceleration).
// The first sample after re-initialization only loads the position; each later one
// runs the full filter step. One sample is worked at a time; the next can be accepted
// in the cycle after the result is loaded, unless a rebuild or re-initialization waits.
// Reset (synchronous, active high) restores defaults and then runs the rebuild and
// re-initialization programs before the first sample is accepted.
`timescale 1ns / 1ps

module kalman_filter_pos_vel_acc_core #(
  parameter int STATE_FRAC_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  kfa_in_if.sink      in_ch,
  kfa_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kfa_pkg::*;

  localparam logic [1:0] REG_DT  = 2'd0;
  localparam logic [1:0] REG_SIG = 2'd1;
  localparam logic [1:0] REG_R   = 2'd2;
  localparam logic [1:0] REG_P   = 2'd3;

  logic [31:0]        time_step;
  logic [30:0]        accel_noise_scale;
  logic [30:0]        measurement_noise;
  logic [30:0]        initial_covariance;
  logic signed [31:0] sample_q;
  logic               cfg_wr;
  logic               rebuild_req;
  logic               reinit_req;
  logic               in_ready;
  logic               out_free;
  logic               load_out;
  logic signed [31:0] hold_pos;
  logic signed [31:0] hold_vel;
  logic signed [31:0] hold_acc;
  kfa_cmd_t           cmd;
  kfa_stat_t          stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    rebuild_req = 1'b0;
    reinit_req = 1'b0;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DT:  rebuild_req = 1'b1;
        REG_SIG: begin
          rebuild_req = 1'b1;
          reinit_req = 1'b1;
        end
        REG_R, REG_P: reinit_req = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DT:  prdata = time_step;
      REG_SIG: prdata = {1'b0, accel_noise_scale};
      REG_R:   prdata = {1'b0, measurement_noise};
      REG_P:   prdata = {1'b0, initial_covariance};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 32'd42949673;
      accel_noise_scale <= 31'd655360;
      measurement_noise <= 31'd655360;
      initial_covariance <= 31'd655360;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DT:  time_step <= pwdata;
        REG_SIG: accel_noise_scale <= pwdata[30:0];
        REG_R:   measurement_noise <= pwdata[30:0];
        REG_P:   initial_covariance <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      sample_q <= in_ch.sample;
    end
  end

  // Output register: a finished result waits here while the next sample runs.
  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.position <= hold_pos;
      out_ch.velocity <= hold_vel;
      out_ch.acceleration <= hold_acc;
    end
  end

  kfa_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .rebuild_req(rebuild_req),
    .reinit_req(reinit_req),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .out_free(out_free),
    .load_out(load_out),
    .cmd(cmd),
    .stat(stat)
  );

  kfa_datapath #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .stat(stat),
    .time_step(time_step),
    .accel_noise_scale(accel_noise_scale),
    .measurement_noise(measurement_noise),
    .initial_covariance(initial_covariance),
    .sample(sample_q),
    .hold_pos(hold_pos),
    .hold_vel(hold_vel),
    .hold_acc(hold_acc)
  );

endmodule
